### hdl/ppd_pkg.sv
// Shared constants and types for the pulse peak detector.
package ppd_pkg;

    localparam int IN_W       = 18;
    localparam int SMOOTH_W   = 24;
    localparam int FRAC_W     = 6;
    localparam int MA_LEN     = 5;
    localparam int WINDOW_LEN = 300;
    localparam int WPOS_W     = $clog2(WINDOW_LEN);
    localparam int CNT_W      = $clog2(MA_LEN + 1);
    localparam int SUM_W      = IN_W + CNT_W;
    localparam int SLOT_W     = (MA_LEN > 1) ? $clog2(MA_LEN) : 1;
    localparam int DIV_W      = SUM_W + FRAC_W;
    localparam int DCNT_W     = $clog2(DIV_W);
    localparam int VAR_W      = 48;
    localparam int K_W        = 10;
    localparam int REF_W      = 8;
    localparam int SQ_STEPS   = VAR_W / 2;
    localparam int SQ_CNT_W   = $clog2(SQ_STEPS);
    localparam int ALPHA_SH   = 16;
    localparam int ADDR_W     = 3;

    localparam logic [11:0]      ALPHA_NUM  = 12'd1311;
    localparam logic [10:0]      HYST_Q8    = 11'd77;
    localparam logic [K_W-1:0]   K_RESET    = 10'd230;
    localparam logic [REF_W-1:0] REF_RESET  = 8'd35;
    localparam logic [SMOOTH_W-1:0] DEV_RESET = 24'd64;
    localparam logic [VAR_W-1:0] VAR_RESET  = 48'd4096;

    // register index, taken from paddr[2]
    localparam logic REG_K_GAIN     = 1'b0;
    localparam logic REG_REFRACTORY = 1'b1;

    // one moving-average result handed to the back end
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } t_ma_item;

endpackage

### hdl/ppd_front.sv
// Front end: sample intake and windowed moving-average sum.
module ppd_front import ppd_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [IN_W-1:0] i_sample,
    input  logic            i_q_full,
    output logic            o_push,
    output t_ma_item        o_item
);

    logic [WPOS_W-1:0] r_wpos, n_wpos;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [SUM_W-1:0]  r_sum;
    logic [IN_W-1:0]   r_hist [MA_LEN];
    logic [IN_W-1:0]   old_val;
    logic [SUM_W-1:0]  base_sum, new_sum;
    logic              full_win;
    logic              wrap;

    assign o_ready  = ~i_q_full;
    assign o_push   = i_valid & ~i_q_full;
    // slots not yet written in this window read as zero
    assign full_win = ({1'b0, r_wpos} >= (WPOS_W + 1)'(MA_LEN));
    assign old_val  = full_win ? r_hist[r_slot] : '0;
    assign base_sum = (r_wpos == '0) ? '0 : r_sum;
    assign new_sum  = base_sum + SUM_W'(i_sample) - SUM_W'(old_val);
    assign wrap     = (r_wpos == WPOS_W'(WINDOW_LEN - 1));
    assign n_wpos   = wrap ? '0 : r_wpos + 1'b1;
    assign n_slot   = (wrap || r_slot == SLOT_W'(MA_LEN - 1)) ? '0 : r_slot + 1'b1;

    always_comb begin
        o_item.sum   = new_sum;
        o_item.count = full_win ? CNT_W'(MA_LEN) : CNT_W'(r_wpos + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos <= '0;
            r_slot <= '0;
            r_sum  <= '0;
        end else if (o_push) begin
            r_wpos <= n_wpos;
            r_slot <= n_slot;
            r_sum  <= new_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_push) begin
            r_hist[r_slot] <= i_sample;
        end
    end

endmodule

### hdl/ppd_queue.sv
// Two-entry queue between front and back ends.
module ppd_queue import ppd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_ma_item i_item,
    input  logic     i_pop,
    output t_ma_item o_item,
    output logic     o_full,
    output logic     o_empty
);

    t_ma_item   r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

### hdl/ppd_back.sv
// Back end: divider, mean/variance tracking, square root and peak decision.
module ppd_back import ppd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  t_ma_item            i_item,
    output logic                o_pop,
    input  logic [K_W-1:0]      i_k_gain,
    input  logic [REF_W-1:0]    i_refractory,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_peak,
    output logic [SMOOTH_W-1:0] o_smoothed,
    output logic                o_armed
);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_DIV  = 9'b000000010,
        ST_MUL  = 9'b000000100,
        ST_VMUL = 9'b000001000,
        ST_VAR  = 9'b000010000,
        ST_SQRT = 9'b000100000,
        ST_THR  = 9'b001000000,
        ST_CMP  = 9'b010000000,
        ST_OUT  = 9'b100000000
    } t_state;

    t_state r_state;

    // divider
    logic [DIV_W-1:0]  r_num;
    logic [CNT_W-1:0]  r_den;
    logic [CNT_W:0]    r_rem;
    logic [DCNT_W-1:0] r_dcnt;
    logic [CNT_W:0]    rem_sh;
    logic              rem_ge;

    // detector state
    logic [SMOOTH_W-1:0] r_mean;
    logic [SMOOTH_W-1:0] r_dev;
    logic [VAR_W-1:0]    r_var;
    logic                r_armed;
    logic [REF_W-1:0]    r_hold;
    logic [SMOOTH_W-1:0] r_prev;

    // datapath pipeline registers
    logic signed [36:0] r_pm;
    logic [47:0]        r_dd;
    logic [59:0]        r_vm;
    logic [59:0]        r_dm;
    logic [33:0]        r_ph;
    logic signed [35:0] r_pl;

    // square root
    logic [VAR_W-1:0]    r_sq_v, r_sq_res, r_sq_bit;
    logic [SQ_CNT_W-1:0] r_sq_cnt;
    logic [VAR_W:0]      sq_try;

    // result
    logic r_res_peak;

    logic [SMOOTH_W-1:0]   x;
    logic signed [24:0]    d;
    logic [SMOOTH_W-1:0]   ad;
    logic signed [26:0]    m_new;
    logic [VAR_W+1:0]      v_new;
    logic signed [10:0]    k_lo;
    logic [26:0]           th_hi;
    logic signed [28:0]    th_lo;
    logic                  out_free;

    assign x      = r_num[SMOOTH_W-1:0];
    assign rem_sh = {r_rem[CNT_W-1:0], r_num[DIV_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_den});
    assign d      = $signed({1'b0, x}) - $signed({1'b0, r_mean});
    assign ad     = d[24] ? SMOOTH_W'(-d) : d[SMOOTH_W-1:0];
    assign m_new  = $signed({3'b000, r_mean}) + 27'($signed(r_pm[36:ALPHA_SH]));
    assign v_new  = {2'b00, r_var} - {7'd0, r_vm[58:ALPHA_SH]} + {7'd0, r_dm[58:ALPHA_SH]};
    assign sq_try = {1'b0, r_sq_res} + {1'b0, r_sq_bit};
    assign k_lo   = $signed({1'b0, i_k_gain}) - $signed(HYST_Q8);
    assign th_hi  = {3'b000, r_mean} + {1'b0, r_ph[33:8]};
    assign th_lo  = $signed({5'd0, r_mean}) + 29'($signed(r_pl[35:8]));
    assign out_free = ~o_valid | i_ready;
    assign o_pop  = (r_state == ST_IDLE) & ~i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mean  <= '0;
            r_dev   <= DEV_RESET;
            r_var   <= VAR_RESET;
            r_armed <= 1'b0;
            r_hold  <= '0;
            r_prev  <= '0;
            o_valid <= 1'b0;
        end else begin
            // in ST_OUT a taken result is replaced by the next one below
            if (o_valid && i_ready && r_state != ST_OUT) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_dcnt == DCNT_W'(DIV_W - 1)) begin
                        r_state <= (r_hold != '0) ? ST_CMP : ST_MUL;
                    end
                end
                ST_MUL:  r_state <= ST_VMUL;
                ST_VMUL: begin
                    if (m_new < 0) begin
                        r_mean <= '0;
                    end else if (m_new > 27'sd16777215) begin
                        r_mean <= '1;
                    end else begin
                        r_mean <= m_new[SMOOTH_W-1:0];
                    end
                    r_state <= ST_VAR;
                end
                ST_VAR: begin
                    r_var   <= (v_new[VAR_W+1:VAR_W] != 2'b00) ? '1 : v_new[VAR_W-1:0];
                    r_state <= ST_SQRT;
                end
                ST_SQRT: begin
                    if (r_sq_cnt == SQ_CNT_W'(SQ_STEPS - 1)) begin
                        r_state <= ST_THR;
                    end
                end
                ST_THR: begin
                    r_dev   <= r_sq_res[SMOOTH_W-1:0];
                    r_state <= ST_CMP;
                end
                ST_CMP: begin
                    if (r_hold != '0) begin
                        r_hold <= r_hold - 1'b1;
                    end else if (!r_armed) begin
                        if ({3'b000, x} > th_hi) begin
                            r_armed <= 1'b1;
                        end
                    end else if (r_prev > x && $signed({5'd0, x}) < th_lo) begin
                        r_hold  <= i_refractory;
                        r_armed <= 1'b0;
                    end
                    r_prev  <= x;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        o_valid <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_num  <= {i_item.sum, FRAC_W'(0)};
                r_den  <= i_item.count;
                r_rem  <= '0;
                r_dcnt <= '0;
            end
            ST_DIV: begin
                r_rem  <= rem_ge ? rem_sh - {1'b0, r_den} : rem_sh;
                r_num  <= {r_num[DIV_W-2:0], rem_ge};
                r_dcnt <= r_dcnt + 1'b1;
            end
            ST_MUL: begin
                r_pm <= $signed({1'b0, ALPHA_NUM}) * d;
                r_dd <= ad * ad;
                r_vm <= r_var * ALPHA_NUM;
            end
            ST_VMUL: begin
                r_dm <= r_dd * ALPHA_NUM;
            end
            ST_VAR: begin
                r_sq_v   <= (v_new[VAR_W+1:VAR_W] != 2'b00) ? '1 : v_new[VAR_W-1:0];
                r_sq_res <= '0;
                r_sq_bit <= VAR_W'(1) << (VAR_W - 2);
                r_sq_cnt <= '0;
            end
            ST_SQRT: begin
                if ({1'b0, r_sq_v} >= sq_try) begin
                    r_sq_v   <= r_sq_v - sq_try[VAR_W-1:0];
                    r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                end else begin
                    r_sq_res <= r_sq_res >> 1;
                end
                r_sq_bit <= r_sq_bit >> 2;
                r_sq_cnt <= r_sq_cnt + 1'b1;
            end
            ST_THR: begin
                r_ph <= i_k_gain * r_sq_res[SMOOTH_W-1:0];
                r_pl <= k_lo * $signed({1'b0, r_sq_res[SMOOTH_W-1:0]});
            end
            ST_CMP: begin
                r_res_peak <= (r_hold == '0) && r_armed && (r_prev > x)
                              && ($signed({5'd0, x}) < th_lo);
            end
            ST_OUT: begin
                if (out_free) begin
                    o_peak     <= r_res_peak;
                    o_smoothed <= x;
                    o_armed    <= r_armed;
                end
            end
            default: ;
        endcase
    end

endmodule

### hdl/pulse_peak_detector_top.sv
// Top level of the pulse peak detector.
//
//  channel   | dir | handshake               | payload
//  ----------+-----+-------------------------+----------------------------------------
//  s_axis    | in  | tvalid / tready         | tdata[17:0] ir_sample
//  m_axis    | out | tvalid / tready         | tdata[0] peak, [24:1] smoothed, [25] armed
//  apb       | in  | psel/penable/pwrite     | 0x0 k_gain, 0x4 refractory_len
//
// Each sample is popped, divided by the average count in a shift-subtract divide,
// then passes the products and variance, the bit-pair square root, and the
// thresholds and output; refractory samples skip the math.
// Reset is synchronous, active low. The front takes samples while its two-entry
// queue has room; the back stalls only on a full output register.
module pulse_peak_detector_top import ppd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [23:0]       s_axis_tdata,   // [17:0] ir_sample
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,   // [0] peak_found, [24:1] smoothed, [25] armed
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [K_W-1:0]      r_k_gain;
    logic [REF_W-1:0]    r_refractory;
    logic                push, pop, q_full, q_empty;
    t_ma_item            f_item, q_item;
    logic                peak, armed;
    logic [SMOOTH_W-1:0] smoothed;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_gain     <= K_RESET;
            r_refractory <= REF_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_K_GAIN:     r_k_gain     <= pwdata[K_W-1:0];
                REG_REFRACTORY: r_refractory <= pwdata[REF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_K_GAIN:     prdata = 32'(r_k_gain);
            REG_REFRACTORY: prdata = 32'(r_refractory);
            default:        prdata = '0;
        endcase
    end

    ppd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_sample (s_axis_tdata[IN_W-1:0]),
        .i_q_full (q_full),
        .o_push   (push),
        .o_item   (f_item)
    );

    ppd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    ppd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_item       (q_item),
        .o_pop        (pop),
        .i_k_gain     (r_k_gain),
        .i_refractory (r_refractory),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_peak       (peak),
        .o_smoothed   (smoothed),
        .o_armed      (armed)
    );

    assign m_axis_tdata = {6'd0, armed, smoothed, peak};

endmodule
